@@ hw/rtl/qvr_pkg.sv @@
package qvr_pkg;

	localparam int VEC_W   = 24;
	localparam int QUAT_W  = 18;
	localparam int PROD_W  = 2 * QUAT_W;
	localparam int MAT_W   = PROD_W + 2;
	localparam int SPLIT   = 19;
	localparam int PART_W  = 44;
	localparam int ACC_W   = 64;
	localparam int FRAC    = 32;
	localparam int RES_W   = ACC_W - FRAC;

	typedef logic signed [VEC_W-1:0]  vec_t;
	typedef logic signed [QUAT_W-1:0] quat_t;
	typedef logic signed [PROD_W-1:0] prod_t;
	typedef logic signed [MAT_W-1:0]  mat_t;
	typedef logic signed [PART_W-1:0] part_t;
	typedef logic signed [ACC_W-1:0]  acc_t;
	typedef logic signed [RES_W-1:0]  res_t;

	localparam acc_t ROUND_HALF = acc_t'(64'sd1 <<< (FRAC - 1));
	localparam res_t OUT_MAX    = res_t'(32'sd8388607);
	localparam res_t OUT_MIN    = res_t'(-32'sd8388608);

endpackage

@@ hw/rtl/quaternion_vector_rotation.sv @@
// channel | dir | tdata (low bit up)                              | tuser
// s_axis  | in  | vec_x, vec_y, vec_z (24 each), quat_w..quat_z (18 each) | -
// m_axis  | out | rot_x, rot_y, rot_z (24 each)                   | clipped
//
// One transfer per cycle sustained while m_axis_tready stays high, through the six
// register stages (products, matrix, split multiplies, partial sums, sum, round).
// arst_n clears all stage valid bits; data registers are not reset.
// A full stage holds while the next one cannot take its data; empty stages keep filling,
// so bubbles close up behind a stalled output.
module quaternion_vector_rotation (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [143:0] s_axis_tdata,   // vec_x, vec_y, vec_z, quat_w, quat_x, quat_y, quat_z
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [71:0]  m_axis_tdata,   // rot_x, rot_y, rot_z
	output logic [0:0]   m_axis_tuser    // clipped
);
	import qvr_pkg::*;

	vec_t  vec [3];
	quat_t quat_w, quat_x, quat_y, quat_z;
	logic  mat_valid, mat_ready;
	mat_t  mat [3][3];
	vec_t  mat_vec [3];
	logic  acc_valid, acc_ready;
	acc_t  acc [3];
	vec_t  rot [3];
	logic  clipped;

	assign vec[0] = s_axis_tdata[23:0];
	assign vec[1] = s_axis_tdata[47:24];
	assign vec[2] = s_axis_tdata[71:48];
	assign quat_w = s_axis_tdata[89:72];
	assign quat_x = s_axis_tdata[107:90];
	assign quat_y = s_axis_tdata[125:108];
	assign quat_z = s_axis_tdata[143:126];

	qvr_matrix u_matrix (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.vec       (vec),
		.quat_w    (quat_w),
		.quat_x    (quat_x),
		.quat_y    (quat_y),
		.quat_z    (quat_z),
		.out_valid (mat_valid),
		.out_ready (mat_ready),
		.mat       (mat),
		.mat_vec   (mat_vec)
	);

	qvr_mac u_mac (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (mat_valid),
		.in_ready  (mat_ready),
		.mat       (mat),
		.vec       (mat_vec),
		.out_valid (acc_valid),
		.out_ready (acc_ready),
		.acc       (acc)
	);

	qvr_round u_round (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (acc_valid),
		.in_ready  (acc_ready),
		.acc       (acc),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.rot       (rot),
		.clipped   (clipped)
	);

	assign m_axis_tdata = {rot[2], rot[1], rot[0]};
	assign m_axis_tuser = clipped;

endmodule

@@ hw/rtl/qvr_matrix.sv @@
module qvr_matrix (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  qvr_pkg::vec_t    vec [3],
	input  qvr_pkg::quat_t   quat_w,
	input  qvr_pkg::quat_t   quat_x,
	input  qvr_pkg::quat_t   quat_y,
	input  qvr_pkg::quat_t   quat_z,
	output logic             out_valid,
	input  logic             out_ready,
	output qvr_pkg::mat_t    mat [3][3],
	output qvr_pkg::vec_t    mat_vec [3]
);
	import qvr_pkg::*;

	logic  vld_s1, vld_s2;
	logic  en_s1, en_s2;
	prod_t ww_s1, xx_s1, yy_s1, zz_s1, xy_s1, wz_s1, wy_s1, xz_s1, yz_s1, wx_s1;
	vec_t  vec_s1 [3];
	vec_t  vec_s2 [3];
	mat_t  mat_s2 [3][3];

	assign en_s2    = !vld_s2 || out_ready;
	assign en_s1    = !vld_s1 || en_s2;
	assign in_ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (en_s1) vld_s1 <= in_valid;
			if (en_s2) vld_s2 <= vld_s1;
		end
	end

	// products of quaternion components
	always_ff @(posedge clk) begin
		if (en_s1 && in_valid) begin
			ww_s1  <= quat_w * quat_w;
			xx_s1  <= quat_x * quat_x;
			yy_s1  <= quat_y * quat_y;
			zz_s1  <= quat_z * quat_z;
			xy_s1  <= quat_x * quat_y;
			wz_s1  <= quat_w * quat_z;
			wy_s1  <= quat_w * quat_y;
			xz_s1  <= quat_x * quat_z;
			yz_s1  <= quat_y * quat_z;
			wx_s1  <= quat_w * quat_x;
			vec_s1 <= vec;
		end
	end

	// rotation matrix, four-square diagonal form
	always_ff @(posedge clk) begin
		if (en_s2 && vld_s1) begin
			mat_s2[0][0] <= mat_t'(ww_s1) + mat_t'(xx_s1) - mat_t'(yy_s1) - mat_t'(zz_s1);
			mat_s2[0][1] <= (mat_t'(xy_s1) - mat_t'(wz_s1)) <<< 1;
			mat_s2[0][2] <= (mat_t'(wy_s1) + mat_t'(xz_s1)) <<< 1;
			mat_s2[1][0] <= (mat_t'(xy_s1) + mat_t'(wz_s1)) <<< 1;
			mat_s2[1][1] <= mat_t'(ww_s1) - mat_t'(xx_s1) + mat_t'(yy_s1) - mat_t'(zz_s1);
			mat_s2[1][2] <= (mat_t'(yz_s1) - mat_t'(wx_s1)) <<< 1;
			mat_s2[2][0] <= (mat_t'(xz_s1) - mat_t'(wy_s1)) <<< 1;
			mat_s2[2][1] <= (mat_t'(yz_s1) + mat_t'(wx_s1)) <<< 1;
			mat_s2[2][2] <= mat_t'(ww_s1) - mat_t'(xx_s1) - mat_t'(yy_s1) + mat_t'(zz_s1);
			vec_s2       <= vec_s1;
		end
	end

	assign out_valid = vld_s2;
	assign mat       = mat_s2;
	assign mat_vec   = vec_s2;

endmodule

@@ hw/rtl/qvr_mac.sv @@
module qvr_mac (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  qvr_pkg::mat_t  mat [3][3],
	input  qvr_pkg::vec_t  vec [3],
	output logic           out_valid,
	input  logic           out_ready,
	output qvr_pkg::acc_t  acc [3]
);
	import qvr_pkg::*;

	logic  vld_s3, vld_s4, vld_s5;
	logic  en_s3, en_s4, en_s5;
	part_t hi_c  [3][3];
	part_t lo_c  [3][3];
	part_t hi_s3 [3][3];
	part_t lo_s3 [3][3];
	acc_t  term_s4 [3][3];
	acc_t  acc_s5 [3];

	assign en_s5    = !vld_s5 || out_ready;
	assign en_s4    = !vld_s4 || en_s5;
	assign en_s3    = !vld_s3 || en_s4;
	assign in_ready = en_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			if (en_s3) vld_s3 <= in_valid;
			if (en_s4) vld_s4 <= vld_s3;
			if (en_s5) vld_s5 <= vld_s4;
		end
	end

	// matrix entry split into signed high and unsigned low halves
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				hi_c[i][j] = $signed(mat[i][j][MAT_W-1:SPLIT]) * vec[j];
				lo_c[i][j] = $signed({1'b0, mat[i][j][SPLIT-1:0]}) * vec[j];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s3 && in_valid) begin
			hi_s3 <= hi_c;
			lo_s3 <= lo_c;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s4 && vld_s3) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					term_s4[i][j] <= (acc_t'(hi_s3[i][j]) <<< SPLIT) + acc_t'(lo_s3[i][j]);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s5 && vld_s4) begin
			for (int i = 0; i < 3; i++) begin
				acc_s5[i] <= term_s4[i][0] + term_s4[i][1] + term_s4[i][2] + ROUND_HALF;
			end
		end
	end

	assign out_valid = vld_s5;
	assign acc       = acc_s5;

endmodule

@@ hw/rtl/qvr_round.sv @@
module qvr_round (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  qvr_pkg::acc_t  acc [3],
	output logic           out_valid,
	input  logic           out_ready,
	output qvr_pkg::vec_t  rot [3],
	output logic           clipped
);
	import qvr_pkg::*;

	logic vld_s6, en_s6;
	res_t res_c [3];
	vec_t rot_c [3];
	logic [2:0] clip_c;
	vec_t rot_s6 [3];
	logic clip_s6;

	assign en_s6    = !vld_s6 || out_ready;
	assign in_ready = en_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
		end else if (en_s6) begin
			vld_s6 <= in_valid;
		end
	end

	// rounding offset is already in acc; the upper word is the floor
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			res_c[i] = acc[i][ACC_W-1:FRAC];
			if (res_c[i] > OUT_MAX) begin
				rot_c[i]  = vec_t'(OUT_MAX);
				clip_c[i] = 1'b1;
			end else if (res_c[i] < OUT_MIN) begin
				rot_c[i]  = vec_t'(OUT_MIN);
				clip_c[i] = 1'b1;
			end else begin
				rot_c[i]  = res_c[i][VEC_W-1:0];
				clip_c[i] = 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s6 && in_valid) begin
			rot_s6  <= rot_c;
			clip_s6 <= |clip_c;
		end
	end

	assign out_valid = vld_s6;
	assign rot       = rot_s6;
	assign clipped   = clip_s6;

endmodule

@@ sim/quaternion_vector_rotation_test.sv @@
`timescale 1ns / 100ps

module quaternion_vector_rotation_test;

	import qvr_pkg::*;

	localparam int ONE_Q       = 65536;   // 1.0 in Q1.16
	localparam int HALF_SQRT2  = 46341;   // cos(45 deg) in Q1.16
	localparam int QUAT_NEG1   = -131072;
	localparam int QUAT_TOP    = 131071;
	localparam int VEC_TOP     = 8388607;
	localparam int VEC_BOTTOM  = -8388608;
	localparam int LONG_HOLD   = 300;
	localparam int IDLE_LIMIT  = 2000;
	localparam int DRAIN_WAIT  = 12;
	localparam int RANDOM_ITEMS = 1100;
	localparam int MAX_PRINTS  = 30;

	typedef struct {
		vec_t  vx, vy, vz;
		quat_t qw, qx, qy, qz;
	} rot_in_t;

	typedef struct {
		vec_t rx, ry, rz;
		logic clip;
	} rot_out_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [143:0] s_axis_tdata = '0;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [71:0]  m_axis_tdata;
	logic [0:0]   m_axis_tuser;

	rot_out_t expected_rot[$];
	int       errors = 0;
	int       accepted = 0;
	int       results_seen = 0;
	int       clipped_seen = 0;
	int       input_stalls = 0;
	int       burst_left = 0;
	int       hold_requests = 0;
	int       idle_cycles = 0;

	quaternion_vector_rotation u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// M*v with M built from an unnormalized quaternion, rounded half up, saturated
	function automatic rot_out_t rotate_vector(rot_in_t it);
		longint w, x, y, z, acc, r;
		longint m[3][3];
		longint v[3];
		longint rot[3];
		rot_out_t res;
		int i;
		w = it.qw; x = it.qx; y = it.qy; z = it.qz;
		v[0] = it.vx; v[1] = it.vy; v[2] = it.vz;
		m[0][0] = w*w + x*x - y*y - z*z;
		m[0][1] = 2 * (x*y - w*z);
		m[0][2] = 2 * (w*y + x*z);
		m[1][0] = 2 * (x*y + w*z);
		m[1][1] = w*w - x*x + y*y - z*z;
		m[1][2] = 2 * (y*z - w*x);
		m[2][0] = 2 * (x*z - w*y);
		m[2][1] = 2 * (y*z + w*x);
		m[2][2] = w*w - x*x - y*y + z*z;
		res.clip = 1'b0;
		for (i = 0; i < 3; i++) begin
			acc = m[i][0] * v[0] + m[i][1] * v[1] + m[i][2] * v[2];
			r = (acc + longint'(ROUND_HALF)) >>> FRAC;
			if (r > longint'(OUT_MAX)) begin
				r = OUT_MAX;
				res.clip = 1'b1;
			end else if (r < longint'(OUT_MIN)) begin
				r = OUT_MIN;
				res.clip = 1'b1;
			end
			rot[i] = r;
		end
		res.rx = vec_t'(rot[0]);
		res.ry = vec_t'(rot[1]);
		res.rz = vec_t'(rot[2]);
		return res;
	endfunction

	function automatic rot_in_t make_item(int vx, int vy, int vz, int qw, int qx, int qy, int qz);
		rot_in_t it;
		it.vx = vec_t'(vx); it.vy = vec_t'(vy); it.vz = vec_t'(vz);
		it.qw = quat_t'(qw); it.qx = quat_t'(qx); it.qy = quat_t'(qy); it.qz = quat_t'(qz);
		return it;
	endfunction

	task automatic report(string msg);
		if (errors < MAX_PRINTS)
			$display("mismatch at %0t: %s", $realtime, msg);
		errors++;
	endtask

	task automatic compare_field(string name, longint got, longint want);
		if (got != want)
			report($sformatf("%s got %0d expected %0d", name, got, want));
	endtask

	// caller sits just after a rising edge
	task automatic send_item(rot_in_t it);
		if (burst_left == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 150) : $urandom_range(1, 12);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {it.qz, it.qy, it.qx, it.qw, it.vz, it.vy, it.vx};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		burst_left--;
	endtask

	// receiver: random stall patterns, plus a long hold on request
	always @(posedge clk) begin
		static int hold_served = 0;
		static int hold_left = 0;
		static int phase_left = 0;
		static int stall_mode = 0;
		if (hold_requests != hold_served) begin
			hold_served = hold_requests;
			hold_left = LONG_HOLD;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else begin
			if (phase_left == 0) begin
				stall_mode = $urandom_range(0, 3);
				phase_left = $urandom_range(20, 200);
			end
			phase_left--;
			case (stall_mode)
				0: m_axis_tready <= 1'b1;
				1: m_axis_tready <= ($urandom_range(0, 3) != 0);
				2: m_axis_tready <= ($urandom_range(0, 1) != 0);
				default: m_axis_tready <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	// scoreboard: check results, then queue the prediction for a new transfer
	always @(posedge clk) begin
		rot_in_t in_item;
		rot_out_t want;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				results_seen++;
				if (m_axis_tuser[0])
					clipped_seen++;
				if (expected_rot.size() == 0) begin
					report("result with nothing expected");
				end else begin
					want = expected_rot.pop_front();
					compare_field("rot_x", vec_t'(m_axis_tdata[23:0]), want.rx);
					compare_field("rot_y", vec_t'(m_axis_tdata[47:24]), want.ry);
					compare_field("rot_z", vec_t'(m_axis_tdata[71:48]), want.rz);
					compare_field("clipped", m_axis_tuser[0], want.clip);
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				in_item.vx = s_axis_tdata[23:0];
				in_item.vy = s_axis_tdata[47:24];
				in_item.vz = s_axis_tdata[71:48];
				in_item.qw = s_axis_tdata[89:72];
				in_item.qx = s_axis_tdata[107:90];
				in_item.qy = s_axis_tdata[125:108];
				in_item.qz = s_axis_tdata[143:126];
				expected_rot.push_back(rotate_vector(in_item));
				accepted++;
			end
			if (s_axis_tvalid && !s_axis_tready)
				input_stalls++;
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
			$display("FAIL");
			$finish;
		end
	end

	task automatic test_identity;
		send_item(make_item(VEC_TOP, VEC_BOTTOM, 0, ONE_Q, 0, 0, 0));
		send_item(make_item(VEC_BOTTOM, VEC_TOP, 12345, ONE_Q, 0, 0, 0));
		send_item(make_item(1, -1, 32768, 0, ONE_Q, 0, 0));
	endtask

	task automatic test_zero_quaternion;
		send_item(make_item(VEC_TOP, VEC_TOP, VEC_TOP, 0, 0, 0, 0));
		send_item(make_item(VEC_BOTTOM, VEC_BOTTOM, VEC_BOTTOM, 0, 0, 0, 0));
	endtask

	task automatic test_full_scale;
		send_item(make_item(VEC_TOP, VEC_TOP, VEC_TOP, QUAT_NEG1, QUAT_NEG1, QUAT_NEG1, QUAT_NEG1));
		send_item(make_item(VEC_BOTTOM, VEC_BOTTOM, VEC_BOTTOM,
			QUAT_TOP, QUAT_TOP, QUAT_TOP, QUAT_TOP));
		send_item(make_item(VEC_BOTTOM, VEC_TOP, VEC_BOTTOM, QUAT_NEG1, 0, 0, 0));
		send_item(make_item(VEC_TOP, VEC_BOTTOM, VEC_TOP, QUAT_TOP, QUAT_NEG1, QUAT_TOP, QUAT_NEG1));
		send_item(make_item(-1, -1, -1, QUAT_NEG1, QUAT_TOP, QUAT_NEG1, QUAT_TOP));
	endtask

	task automatic test_axis_turns;
		send_item(make_item(65536, 98304, -32768, HALF_SQRT2, HALF_SQRT2, 0, 0));
		send_item(make_item(65536, 98304, -32768, HALF_SQRT2, 0, HALF_SQRT2, 0));
		send_item(make_item(65536, 98304, -32768, HALF_SQRT2, 0, 0, -HALF_SQRT2));
		send_item(make_item(4000000, -4000000, 3000000, 0, 0, 0, ONE_Q));
	endtask

	// w = 2^-8 makes M = 2^-16 * I, so v = +-2^15 lands exactly on a half
	task automatic test_rounding_ties;
		send_item(make_item(32768, -32768, 32767, 256, 0, 0, 0));
		send_item(make_item(-32769, 98304, -98304, 256, 0, 0, 0));
		send_item(make_item(32768, 0, -32768, 0, 256, 0, 0));
	endtask

	function automatic rot_in_t random_item();
		rot_in_t it;
		int pick;
		pick = $urandom_range(0, 9);
		if (pick < 5) begin
			it.qw = quat_t'(int'($urandom_range(0, 2 * HALF_SQRT2)) - HALF_SQRT2);
			it.qx = quat_t'(int'($urandom_range(0, 2 * HALF_SQRT2)) - HALF_SQRT2);
			it.qy = quat_t'(int'($urandom_range(0, 2 * HALF_SQRT2)) - HALF_SQRT2);
			it.qz = quat_t'(int'($urandom_range(0, 2 * HALF_SQRT2)) - HALF_SQRT2);
		end else begin
			it.qw = quat_t'($urandom());
			it.qx = quat_t'($urandom());
			it.qy = quat_t'($urandom());
			it.qz = quat_t'($urandom());
		end
		if (pick < 3) begin
			it.vx = vec_t'(int'($urandom_range(0, 1 << 18)) - (1 << 17));
			it.vy = vec_t'(int'($urandom_range(0, 1 << 18)) - (1 << 17));
			it.vz = vec_t'(int'($urandom_range(0, 1 << 18)) - (1 << 17));
		end else begin
			it.vx = vec_t'($urandom());
			it.vy = vec_t'($urandom());
			it.vz = vec_t'($urandom());
		end
		return it;
	endfunction

	task automatic test_random_rotations(int count);
		repeat (count) send_item(random_item());
	endtask

	task automatic test_long_output_stall;
		hold_requests++;
		burst_left = 200;
		repeat (60) send_item(random_item());
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_identity();
		test_zero_quaternion();
		test_full_scale();
		test_axis_turns();
		test_rounding_ties();
		test_random_rotations(RANDOM_ITEMS / 2);
		test_long_output_stall();
		test_random_rotations(RANDOM_ITEMS / 2);
		s_axis_tvalid <= 1'b0;
		while (expected_rot.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		$display("%0d rotations sent, %0d results checked, %0d of them clipped",
			accepted, results_seen, clipped_seen);
		$display("input held off for %0d cycles under output back-pressure", input_stalls);
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
